/* rtl/crl_pkg.sv */
// crl_pkg: shared types and constants for the connect rate limiter
// no dependencies; imported by crl_ctrl, crl_dp and connect_rate_limiter_core
package crl_pkg;

  // field widths
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned INTERVAL_W = 20;
  localparam int unsigned LIMIT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  // sliding window length in ms
  localparam logic [TIME_W:0] WINDOW_MS = 49'd10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONNECTS = 1'b1;

  // item commands
  localparam logic CMD_QUERY   = 1'b0;
  localparam logic CMD_CONNECT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;  // capture command and time of an accepted item
    logic drop;       // drop the oldest kept attempt
    logic write;      // record now as a new attempt and last start
    logic calc;       // register the wakeup candidates
    logic load_out;   // load the result register
  } crl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic prune_hit;  // oldest kept attempt has left the window
    logic at_limit;   // kept attempts reach the effective limit
    logic is_connect; // current item is a connect-started
    logic out_free;   // result register can take a new result
  } crl_status_t;

endpackage

/* rtl/crl_ctrl.sv */
// crl_ctrl: sequencer for the connect rate limiter
// depends on crl_pkg for the command and status structs
module crl_ctrl import crl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  crl_status_t status_i,
  output crl_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_PRUNE  = 7'b0000100,
    S_TRIM   = 7'b0001000,
    S_SETTLE = 7'b0010000,
    S_WAKE   = 7'b0100000,
    S_OUT    = 7'b1000000
  } crl_state_e;

  crl_state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_READ;
        end
      end
      // wait for the oldest entry to come out of the memory
      S_READ: begin
        state_d = S_PRUNE;
      end
      S_PRUNE: begin
        if (status_i.prune_hit) begin
          cmd_o.drop = 1'b1;
          state_d    = S_READ;
        end else if (status_i.is_connect) begin
          state_d = S_TRIM;
        end else begin
          state_d = S_WAKE;
        end
      end
      // drop down below the limit, then append
      S_TRIM: begin
        if (status_i.at_limit) begin
          cmd_o.drop = 1'b1;
        end else begin
          cmd_o.write = 1'b1;
          state_d     = S_SETTLE;
        end
      end
      S_SETTLE: begin
        state_d = S_WAKE;
      end
      S_WAKE: begin
        cmd_o.calc = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* rtl/crl_dp.sv */
// crl_dp: datapath of the connect rate limiter: config registers, attempt ring,
// wakeup arithmetic and result register; depends on crl_pkg
module crl_dp import crl_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [INTERVAL_W-1:0] cfg_wdata_i,
  input  logic                  command_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  crl_cmd_t              cmd_i,
  output crl_status_t           status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TIME_W-1:0]     wakeup_ms_o,
  output logic [LIMIT_W-1:0]    attempts_in_window_o
);

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned EW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [EW-1:0] MAX_E    = EW'(RING_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
  localparam logic [CW:0]   DEPTH_S  = (CW+1)'(RING_DEPTH);

  // configuration registers
  logic [INTERVAL_W-1:0] interval_q;
  logic [LIMIT_W-1:0]    limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      limit_q    <= LIMIT_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_INTERVAL: interval_q <= cfg_wdata_i;
        CFG_MAX_CONNECTS: limit_q    <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limit clamped to one and the ring depth
  logic [EW-1:0] limit_e, eff_limit;
  assign limit_e   = EW'(limit_q);
  always_comb begin
    priority if (limit_e == '0) begin
      eff_limit = EW'(1);
    end else if (limit_e > MAX_E) begin
      eff_limit = MAX_E;
    end else begin
      eff_limit = limit_e;
    end
  end

  // current item
  logic              cmd_q;
  logic [TIME_W-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q <= command_i;
      now_q <= now_ms_i;
    end
  end

  // ring pointers and last start
  logic [IW-1:0]     oldest_q, oldest_d;
  logic [CW-1:0]     count_q, count_d;
  logic [TIME_W-1:0] last_q;
  logic              last_valid_q;
  logic [CW:0]       wr_sum;
  logic [IW-1:0]     wr_idx;

  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    if (cmd_i.drop) begin
      oldest_d = (oldest_q == LAST_IDX) ? '0 : oldest_q + IW'(1);
      count_d  = count_q - CW'(1);
    end else if (cmd_i.write) begin
      count_d = count_q + CW'(1);
    end
  end

  // slot after the newest kept attempt, wrapped once
  always_comb begin
    wr_sum = (CW+1)'(oldest_q) + (CW+1)'(count_q);
    if (wr_sum >= DEPTH_S) begin
      wr_sum = wr_sum - DEPTH_S;
    end
    wr_idx = wr_sum[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q     <= '0;
      count_q      <= '0;
      last_valid_q <= 1'b0;
      last_q       <= '0;
    end else begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
      if (cmd_i.write) begin
        last_valid_q <= 1'b1;
        last_q       <= now_q;
      end
    end
  end

  // attempt memory, oldest entry read every cycle
  logic [TIME_W-1:0] mem_q [RING_DEPTH];
  logic [TIME_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem_q[wr_idx] <= now_q;
    end
    rd_data_q <= mem_q[oldest_q];
  end

  // window checks
  logic [TIME_W:0] oldest_end;
  logic            full;
  assign oldest_end = {1'b0, rd_data_q} + WINDOW_MS;
  assign full       = (EW'(count_q) >= eff_limit);

  // wakeup candidates, registered before the final max
  logic [TIME_W:0] cand_a_q, cand_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      cand_a_q <= last_valid_q ? ({1'b0, last_q} + (TIME_W+1)'(interval_q)) : '0;
      cand_b_q <= (count_q != '0 && full) ? oldest_end : '0;
    end
  end

  logic [TIME_W:0]   max_ab, max_all;
  logic [TIME_W-1:0] wake_sat;
  assign max_ab   = (cand_a_q > cand_b_q) ? cand_a_q : cand_b_q;
  assign max_all  = (max_ab > {1'b0, now_q}) ? max_ab : {1'b0, now_q};
  assign wake_sat = max_all[TIME_W] ? '1 : max_all[TIME_W-1:0];

  // result register
  logic              out_valid_q;
  logic [TIME_W-1:0] out_wake_q;
  logic [LIMIT_W-1:0] out_count_q;
  logic [EW-1:0]     count_e;
  assign count_e = EW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_wake_q  <= wake_sat;
      out_count_q <= count_e[LIMIT_W-1:0];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign wakeup_ms_o          = out_wake_q;
  assign attempts_in_window_o = out_count_q;

  // status back to the sequencer
  assign status_o.prune_hit  = (count_q != '0) && (oldest_end <= {1'b0, now_q});
  assign status_o.at_limit   = full;
  assign status_o.is_connect = (cmd_q == CMD_CONNECT);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(RING_DEPTH))
    else $error("kept attempt count above ring depth");

  a_drop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop |-> count_q != '0)
    else $error("drop from an empty ring");

  a_write_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> EW'(count_q) < eff_limit)
    else $error("append with the ring at its limit");

  a_wake_not_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_wake_q >= now_q)
    else $error("wakeup earlier than the item time");

endmodule

/* rtl/connect_rate_limiter_core.sv */
// connect_rate_limiter_core: top level of the connect rate limiter
// depends on crl_pkg, crl_ctrl and crl_dp
//
// Paces connection attempts to one destination with a ten second sliding
// window log of attempt start times kept in an on-chip ring.
// Input channel (in_valid_i / in_stall_o): command_i (0 query, 1 connect
// started) and now_ms_i. Output channel (out_valid_o / out_stall_i):
// wakeup_ms_o and attempts_in_window_o, one result per item.
// The config port (cfg_we_i, cfg_index_i, cfg_wdata_i) writes the minimum
// reconnect interval (index 0) and the window limit (index 1).
// One item is worked at a time. A query prunes the entries that have left
// the window, each waiting on the registered memory read of the oldest
// entry, then registers the wakeup candidates and loads the result register.
// A connect also trims to the limit and appends before the wakeup step.
// The next item is accepted the cycle after its result is loaded.
// Reset clears the ring pointers, the last start and the output valid;
// registers return to interval 0 and limit 16; memory contents are not
// cleared. A stalled result holds in the output register; the sequencer
// waits before loading the next one until it is taken.
module connect_rate_limiter_core import crl_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [INTERVAL_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TIME_W-1:0]     wakeup_ms_o,
  output logic [LIMIT_W-1:0]    attempts_in_window_o
);

  crl_cmd_t    cmd;
  crl_status_t status;

  // sequencer
  crl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  crl_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .command_i            (command_i),
    .now_ms_i             (now_ms_i),
    .cmd_i                (cmd),
    .status_o             (status),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .wakeup_ms_o          (wakeup_ms_o),
    .attempts_in_window_o (attempts_in_window_o)
  );

endmodule
